/* rtl/tse_pkg.sv */
// Shared types and constants for the TLS ClientHello host name extractor.
// Used by the parser, the top level and the port checker; depends on nothing.
`default_nettype none

package tse_pkg;

   localparam logic [7:0] REC_TYPE_HANDSHAKE   = 8'd22;
   localparam logic [7:0] HS_TYPE_CLIENT_HELLO = 8'd1;
   localparam logic [7:0] NAME_TYPE_HOST       = 8'd0;
   localparam int unsigned HELLO_BODY_POS      = 9;
   localparam int unsigned VERSION_RANDOM_LEN  = 34;
   localparam int unsigned RECORD_HEADER_LEN   = 5;
   localparam int unsigned MIN_NAME_EXT_LEN    = 5;

   localparam logic KIND_NAME    = 1'b0;
   localparam logic KIND_VERDICT = 1'b1;

   localparam int unsigned RSP_DEPTH = 4;
   localparam int unsigned RSP_PTR_BITS = $clog2(RSP_DEPTH);

   typedef struct packed {
      logic       result_kind;
      logic [7:0] name_byte;
      logic       sni_found;
      logic       run_last;
   } rsp_entry_type;

   typedef struct packed {
      logic       name_hit;
      logic [7:0] name_byte;
      logic       verdict;
      logic       found;
   } parse_out_type;

endpackage

`default_nettype wire

/* rtl/tse_if.sv */
// Valid/ready channel interfaces for packet bytes in and result words out.
// Standalone; no package dependency.
`default_nettype none

interface tse_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       packet_end;

   modport source (output valid, output data_byte, output packet_end, input ready);
   modport sink   (input valid, input data_byte, input packet_end, output ready);
endinterface

interface tse_rsp_if;
   logic       valid;
   logic       ready;
   logic       result_kind;
   logic [7:0] name_byte;
   logic       sni_found;
   logic       run_last;

   modport source (output valid, output result_kind, output name_byte,
                   output sni_found, output run_last, input ready);
   modport sink   (input valid, input result_kind, input name_byte,
                   input sni_found, input run_last, output ready);
endinterface

`default_nettype wire

/* rtl/tse_parser.sv */
// ClientHello record parser: position, bounds and phase state, one byte per step.
// Depends on tse_pkg.
`default_nettype none

module tse_parser #(
   parameter int unsigned POSITION_BITS = 17
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 step,
   input  wire logic [7:0]           data_byte,
   input  wire logic                 packet_end,
   output tse_pkg::parse_out_type    result
);

   localparam int unsigned PW = POSITION_BITS;
   localparam int unsigned WW = POSITION_BITS + 1;
   localparam logic [PW-1:0] POS_MAX = {PW{1'b1}};
   localparam logic [WW-1:0] SESSION_START =
      WW'(tse_pkg::HELLO_BODY_POS + tse_pkg::VERSION_RANDOM_LEN);
   localparam logic [WW-1:0] MIN_RECORD_END =
      WW'(tse_pkg::HELLO_BODY_POS + tse_pkg::VERSION_RANDOM_LEN + 1);

   typedef enum logic [3:0] {
      PH_HEADER,
      PH_SESSION_LEN,
      PH_CIPHER_LEN,
      PH_COMP_LEN,
      PH_EXTS_LEN,
      PH_EXT_HEADER,
      PH_LIST_LEN,
      PH_NAME_HEADER,
      PH_NAME_BYTES,
      PH_IDLE
   } phase_type;

   phase_type     phase_ff, phase_in;
   logic [PW-1:0] pos_ff, pos_in;
   logic [PW-1:0] rec_end_ff, rec_end_in;
   logic [PW-1:0] exts_end_ff, exts_end_in;
   logic [PW-1:0] ext_end_ff, ext_end_in;
   logic [PW-1:0] list_end_ff, list_end_in;
   logic [PW-1:0] seg_end_ff, seg_end_in;
   logic [7:0]    acc_ff, acc_in;
   logic          is_name_ff, is_name_in;
   logic          complete_ff, complete_in;
   logic          failed_ff, failed_in;

   logic [WW-1:0] p_w, c_w, len_w, b_w, len_sum, b_sum;
   logic [WW-1:0] rec_w, exts_w, ext_w, list_w, seg_w;
   logic [PW-1:0] off;
   logic [15:0]   len16;
   logic          active;
   logic          name_hit;
   logic          found;

   always_comb begin
      len16   = {acc_ff, data_byte};
      p_w     = {1'b0, pos_ff};
      c_w     = p_w + WW'(1);
      len_w   = {{(WW-16){1'b0}}, len16};
      b_w     = {{(WW-8){1'b0}}, data_byte};
      len_sum = c_w + len_w;
      b_sum   = c_w + b_w;
      rec_w   = {1'b0, rec_end_ff};
      exts_w  = {1'b0, exts_end_ff};
      ext_w   = {1'b0, ext_end_ff};
      list_w  = {1'b0, list_end_ff};
      seg_w   = {1'b0, seg_end_ff};
      off     = pos_ff - seg_end_ff;
      active  = (pos_ff >= seg_end_ff);

      phase_in    = phase_ff;
      rec_end_in  = rec_end_ff;
      exts_end_in = exts_end_ff;
      ext_end_in  = ext_end_ff;
      list_end_in = list_end_ff;
      seg_end_in  = seg_end_ff;
      acc_in      = acc_ff;
      is_name_in  = is_name_ff;
      complete_in = complete_ff;
      failed_in   = failed_ff;
      name_hit    = 1'b0;

      case (phase_ff)
         PH_NAME_BYTES: begin
            name_hit = 1'b1;
            if (c_w >= seg_w) begin
               complete_in = 1'b1;
               phase_in    = PH_IDLE;
            end
         end
         PH_HEADER: begin
            if (active) begin
               if (off == PW'(0) && data_byte != tse_pkg::REC_TYPE_HANDSHAKE) begin
                  failed_in = 1'b1;
                  phase_in  = PH_IDLE;
               end else if (off == PW'(3)) begin
                  acc_in = data_byte;
               end else if (off == PW'(4)) begin
                  rec_end_in = PW'(tse_pkg::RECORD_HEADER_LEN) + PW'(len16);
               end else if (off == PW'(5) && data_byte != tse_pkg::HS_TYPE_CLIENT_HELLO) begin
                  failed_in = 1'b1;
                  phase_in  = PH_IDLE;
               end else if (off >= PW'(8)) begin
                  if (rec_w < MIN_RECORD_END) begin
                     failed_in = 1'b1;
                     phase_in  = PH_IDLE;
                  end else begin
                     seg_end_in = SESSION_START[PW-1:0];
                     phase_in   = PH_SESSION_LEN;
                  end
               end
            end
         end
         PH_SESSION_LEN, PH_COMP_LEN: begin
            if (active) begin
               if (b_sum + WW'(2) > rec_w) begin
                  failed_in = 1'b1;
                  phase_in  = PH_IDLE;
               end else begin
                  seg_end_in = b_sum[PW-1:0];
                  phase_in   = (phase_ff == PH_SESSION_LEN) ? PH_CIPHER_LEN : PH_EXTS_LEN;
               end
            end
         end
         PH_CIPHER_LEN: begin
            if (active) begin
               if (off == PW'(0)) begin
                  acc_in = data_byte;
               end else if (len_sum + WW'(1) > rec_w) begin
                  failed_in = 1'b1;
                  phase_in  = PH_IDLE;
               end else begin
                  seg_end_in = len_sum[PW-1:0];
                  phase_in   = PH_COMP_LEN;
               end
            end
         end
         PH_EXTS_LEN: begin
            if (active) begin
               if (off == PW'(0)) begin
                  acc_in = data_byte;
               end else begin
                  exts_end_in = len_sum[PW-1:0];
                  if (len_sum > rec_w) begin
                     failed_in = 1'b1;
                     phase_in  = PH_IDLE;
                  end else begin
                     seg_end_in = c_w[PW-1:0];
                     phase_in   = PH_EXT_HEADER;
                  end
               end
            end
         end
         PH_EXT_HEADER: begin
            if (active) begin
               if (off == PW'(0)) begin
                  if (p_w + WW'(4) > exts_w) begin
                     failed_in = 1'b1;
                     phase_in  = PH_IDLE;
                  end else begin
                     acc_in = data_byte;
                  end
               end else if (off == PW'(1)) begin
                  is_name_in = (len16 == 16'd0);
               end else if (off == PW'(2)) begin
                  acc_in = data_byte;
               end else if (len_sum > exts_w) begin
                  failed_in = 1'b1;
                  phase_in  = PH_IDLE;
               end else begin
                  ext_end_in = len_sum[PW-1:0];
                  if (is_name_ff && len16 >= 16'(tse_pkg::MIN_NAME_EXT_LEN)) begin
                     seg_end_in = c_w[PW-1:0];
                     phase_in   = PH_LIST_LEN;
                  end else begin
                     seg_end_in = len_sum[PW-1:0];
                  end
               end
            end
         end
         PH_LIST_LEN: begin
            if (active) begin
               if (off == PW'(0)) begin
                  acc_in = data_byte;
               end else begin
                  list_end_in = len_sum[PW-1:0];
                  if (len_sum > ext_w) begin
                     failed_in = 1'b1;
                     phase_in  = PH_IDLE;
                  end else begin
                     seg_end_in = c_w[PW-1:0];
                     phase_in   = PH_NAME_HEADER;
                  end
               end
            end
         end
         PH_NAME_HEADER: begin
            if (active) begin
               if (off == PW'(0)) begin
                  if (p_w + WW'(3) > list_w) begin
                     // list exhausted: resume the extension walk at this extension's end
                     seg_end_in = ext_end_ff;
                     phase_in   = PH_EXT_HEADER;
                     if (pos_ff == ext_end_ff) begin
                        if (p_w + WW'(4) > exts_w) begin
                           failed_in = 1'b1;
                           phase_in  = PH_IDLE;
                        end else begin
                           acc_in = data_byte;
                        end
                     end
                  end else begin
                     is_name_in = (data_byte == tse_pkg::NAME_TYPE_HOST);
                  end
               end else if (off == PW'(1)) begin
                  acc_in = data_byte;
               end else if (len_sum > list_w) begin
                  failed_in = 1'b1;
                  phase_in  = PH_IDLE;
               end else begin
                  seg_end_in = len_sum[PW-1:0];
                  if (is_name_ff && len16 != 16'd0) begin
                     phase_in = PH_NAME_BYTES;
                  end
               end
            end
         end
         default: begin
         end
      endcase

      pos_in = (pos_ff == POS_MAX) ? pos_ff : pos_ff + PW'(1);
      found  = complete_in && !failed_in && (pos_in >= rec_end_in);

      result.name_hit  = name_hit;
      result.name_byte = data_byte;
      result.verdict   = packet_end;
      result.found     = found;
   end

   always_ff @(posedge clock) begin
      if (reset || (step && packet_end)) begin
         phase_ff    <= PH_HEADER;
         pos_ff      <= '0;
         rec_end_ff  <= '0;
         exts_end_ff <= '0;
         ext_end_ff  <= '0;
         list_end_ff <= '0;
         seg_end_ff  <= '0;
         acc_ff      <= '0;
         is_name_ff  <= 1'b0;
         complete_ff <= 1'b0;
         failed_ff   <= 1'b0;
      end else if (step) begin
         phase_ff    <= phase_in;
         pos_ff      <= pos_in;
         rec_end_ff  <= rec_end_in;
         exts_end_ff <= exts_end_in;
         ext_end_ff  <= ext_end_in;
         list_end_ff <= list_end_in;
         seg_end_ff  <= seg_end_in;
         acc_ff      <= acc_in;
         is_name_ff  <= is_name_in;
         complete_ff <= complete_in;
         failed_ff   <= failed_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/tls_sni_extractor_core.sv */
// Top level of the TLS ClientHello host name extractor: input word register,
// parser and a small result queue. Depends on tse_pkg, tse_if and tse_parser.
//
//   channel   dir  payload                                          handshake
//   req_chan  in   data_byte[7:0], packet_end                       valid/ready
//   rsp_chan  out  result_kind, name_byte[7:0], sni_found, run_last valid/ready
//
// One packet byte is taken per cycle while the result queue has room; the byte is registered
// first, and its words are written into the queue when the parser steps on it.
// A byte yields zero, one or two words: a host name byte, a verdict, or both.
// The parser steps only when the four-entry result queue has room for two words.
// Synchronous reset empties the input register and the queue and restarts the parse.
`default_nettype none

module tls_sni_extractor_core #(
   parameter int unsigned POSITION_BITS = 17
) (
   input  wire logic     clock,
   input  wire logic     reset,
   tse_req_if.sink       req_chan,
   tse_rsp_if.source     rsp_chan
);

   localparam int unsigned PB = tse_pkg::RSP_PTR_BITS;
   localparam int unsigned CB = tse_pkg::RSP_PTR_BITS + 1;

   logic                   in_valid_ff;
   logic [7:0]             in_byte_ff;
   logic                   in_end_ff;
   tse_pkg::rsp_entry_type queue_ff [tse_pkg::RSP_DEPTH];
   logic [PB-1:0]          wr_ptr_ff, wr_ptr_in;
   logic [PB-1:0]          rd_ptr_ff, rd_ptr_in;
   logic [CB-1:0]          count_ff, count_in;
   logic [PB-1:0]          second_idx;
   logic                   step;
   logic                   pop;
   tse_pkg::parse_out_type parse_out;
   tse_pkg::rsp_entry_type name_word;
   tse_pkg::rsp_entry_type verdict_word;
   tse_pkg::rsp_entry_type head;

   tse_parser #(
      .POSITION_BITS (POSITION_BITS)
   ) u_parser (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .data_byte  (in_byte_ff),
      .packet_end (in_end_ff),
      .result     (parse_out)
   );

   always_comb begin
      step           = in_valid_ff && (count_ff <= CB'(tse_pkg::RSP_DEPTH - 2));
      pop            = (count_ff != '0) && rsp_chan.ready;
      req_chan.ready = !in_valid_ff || step;

      name_word.result_kind    = tse_pkg::KIND_NAME;
      name_word.name_byte      = parse_out.name_byte;
      name_word.sni_found      = 1'b0;
      name_word.run_last       = !parse_out.verdict;
      verdict_word.result_kind = tse_pkg::KIND_VERDICT;
      verdict_word.name_byte   = 8'd0;
      verdict_word.sni_found   = parse_out.found;
      verdict_word.run_last    = 1'b1;

      second_idx = wr_ptr_ff + PB'(parse_out.name_hit);
      wr_ptr_in  = wr_ptr_ff;
      count_in   = count_ff - CB'(pop);
      if (step) begin
         wr_ptr_in = wr_ptr_ff + PB'(parse_out.name_hit) + PB'(parse_out.verdict);
         count_in  = count_in + CB'(parse_out.name_hit) + CB'(parse_out.verdict);
      end
      rd_ptr_in = rd_ptr_ff + PB'(pop);

      head                 = queue_ff[rd_ptr_ff];
      rsp_chan.valid       = (count_ff != '0);
      rsp_chan.result_kind = head.result_kind;
      rsp_chan.name_byte   = head.name_byte;
      rsp_chan.sni_found   = head.sni_found;
      rsp_chan.run_last    = head.run_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         count_ff    <= '0;
      end else begin
         if (req_chan.ready) begin
            in_valid_ff <= req_chan.valid;
         end
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (req_chan.valid && req_chan.ready) begin
         in_byte_ff <= req_chan.data_byte;
         in_end_ff  <= req_chan.packet_end;
      end
      if (step && parse_out.name_hit) begin
         queue_ff[wr_ptr_ff] <= name_word;
      end
      if (step && parse_out.verdict) begin
         queue_ff[second_idx] <= verdict_word;
      end
   end

endmodule

`default_nettype wire

/* rtl/tse_checker.sv */
// Port-level checks for the host name extractor, bound to the top level.
// Depends on the top level's channel ports only.
`default_nettype none

module tse_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic       rsp_result_kind,
   input wire logic [7:0] rsp_name_byte,
   input wire logic       rsp_sni_found,
   input wire logic       rsp_run_last
);

   a_verdict_closes_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind |-> rsp_run_last && rsp_name_byte == 8'd0)
      else $error("verdict word without run end or with a name byte");

   a_open_run_is_name: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_run_last |-> !rsp_result_kind && !rsp_sni_found)
      else $error("word inside a run is not a plain name byte");

   a_idle_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result word offered straight after reset");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result_kind)
         && $stable(rsp_name_byte) && $stable(rsp_sni_found) && $stable(rsp_run_last))
      else $error("stalled result word changed");

endmodule

bind tls_sni_extractor_core tse_checker u_tse_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_result_kind (rsp_chan.result_kind),
   .rsp_name_byte   (rsp_chan.name_byte),
   .rsp_sni_found   (rsp_chan.sni_found),
   .rsp_run_last    (rsp_chan.run_last)
);

`default_nettype wire

/* tb/sv/tse_sni_checker.sv */
// Port checker for the TLS ClientHello host name extractor: watches both channels,
// predicts the result words of every accepted packet byte and compares them in order.
// Depends on tse_pkg and the channel interfaces in tse_if.
module tse_sni_checker #(
   parameter int unsigned POSITION_BITS = 17
) (
   input  logic        clock,
   input  logic        reset,
   tse_req_if          req_chan,
   tse_rsp_if          rsp_chan,
   output int unsigned fail_count,
   output int unsigned pending_count
);

   typedef longint unsigned pos_type;

   localparam pos_type POS_MAX = (pos_type'(1) << POSITION_BITS) - 1;
   localparam logic [15:0] EXT_SERVER_NAME = 16'd0;
   localparam int unsigned SHOW_LIMIT = 10;

   typedef enum logic [3:0] {
      ST_RECORD, ST_SESSION, ST_CIPHERS, ST_COMPRESSION, ST_EXT_LIST,
      ST_EXT_HEAD, ST_NAME_LIST, ST_NAME_HEAD, ST_NAME_BODY, ST_DONE
   } stage_type;

   stage_type              stage;
   pos_type                at, rec_end, exts_end, ext_end, list_end, seg_end;
   logic [15:0]            acc;
   logic                   is_host, name_done, broken;
   tse_pkg::rsp_entry_type due_words[$];

   function automatic void clear_parse();
      stage     = ST_RECORD;
      at        = 0;
      rec_end   = 0;
      exts_end  = 0;
      ext_end   = 0;
      list_end  = 0;
      seg_end   = 0;
      acc       = '0;
      is_host   = 1'b0;
      name_done = 1'b0;
      broken    = 1'b0;
   endfunction

   function automatic void abandon();
      broken = 1'b1;
      stage  = ST_DONE;
   endfunction

   // Returns 1 when the byte at p belongs to the host name being extracted.
   function automatic bit take_byte(input pos_type p, input logic [7:0] b);
      pos_type off, len, nxt;
      for (int pass = 0; pass < 2; pass++) begin
         if (stage == ST_NAME_BODY) begin
            if (p + 1 >= seg_end) begin
               name_done = 1'b1;
               stage     = ST_DONE;
            end
            return 1'b1;
         end
         if (stage == ST_DONE || p < seg_end) return 1'b0;
         off = p - seg_end;
         len = pos_type'({acc[7:0], b});
         nxt = p + 1;
         case (stage)
            ST_RECORD: begin
               if (off == 0 && b != tse_pkg::REC_TYPE_HANDSHAKE) abandon();
               else if (off == 3) acc = 16'(b);
               else if (off == 4) rec_end = tse_pkg::RECORD_HEADER_LEN + len;
               else if (off == 5 && b != tse_pkg::HS_TYPE_CLIENT_HELLO) abandon();
               else if (off >= 8) begin
                  if (rec_end < tse_pkg::HELLO_BODY_POS + tse_pkg::VERSION_RANDOM_LEN + 1)
                     abandon();
                  else begin
                     seg_end = tse_pkg::HELLO_BODY_POS + tse_pkg::VERSION_RANDOM_LEN;
                     stage   = ST_SESSION;
                  end
               end
            end
            ST_SESSION: begin
               if (nxt + b + 2 > rec_end) abandon();
               else begin
                  seg_end = nxt + b;
                  stage   = ST_CIPHERS;
               end
            end
            ST_CIPHERS: begin
               if (off == 0) acc = 16'(b);
               else if (nxt + len + 1 > rec_end) abandon();
               else begin
                  seg_end = nxt + len;
                  stage   = ST_COMPRESSION;
               end
            end
            ST_COMPRESSION: begin
               if (nxt + b + 2 > rec_end) abandon();
               else begin
                  seg_end = nxt + b;
                  stage   = ST_EXT_LIST;
               end
            end
            ST_EXT_LIST: begin
               if (off == 0) acc = 16'(b);
               else begin
                  exts_end = nxt + len;
                  if (exts_end > rec_end) abandon();
                  else begin
                     seg_end = nxt;
                     stage   = ST_EXT_HEAD;
                  end
               end
            end
            ST_EXT_HEAD: begin
               if (off == 0) begin
                  if (p + 4 > exts_end) abandon();
                  else acc = 16'(b);
               end else if (off == 1) begin
                  is_host = (len == EXT_SERVER_NAME);
               end else if (off == 2) begin
                  acc = 16'(b);
               end else if (nxt + len > exts_end) begin
                  abandon();
               end else begin
                  ext_end = nxt + len;
                  if (is_host && len >= tse_pkg::MIN_NAME_EXT_LEN) begin
                     seg_end = nxt;
                     stage   = ST_NAME_LIST;
                  end else begin
                     seg_end = ext_end;
                  end
               end
            end
            ST_NAME_LIST: begin
               if (off == 0) acc = 16'(b);
               else begin
                  list_end = nxt + len;
                  if (list_end > ext_end) abandon();
                  else begin
                     seg_end = nxt;
                     stage   = ST_NAME_HEAD;
                  end
               end
            end
            ST_NAME_HEAD: begin
               if (off == 0) begin
                  // list exhausted: resume the extension walk with this same byte
                  if (p + 3 > list_end) begin
                     seg_end = ext_end;
                     stage   = ST_EXT_HEAD;
                     continue;
                  end
                  is_host = (b == tse_pkg::NAME_TYPE_HOST);
               end else if (off == 1) begin
                  acc = 16'(b);
               end else if (nxt + len > list_end) begin
                  abandon();
               end else begin
                  seg_end = nxt + len;
                  if (is_host && len > 0) stage = ST_NAME_BODY;
               end
            end
            default: ;
         endcase
         return 1'b0;
      end
      return 1'b0;
   endfunction

   function automatic void step_parser(input logic [7:0] b, input logic last);
      tse_pkg::rsp_entry_type w;
      if (take_byte(at, b)) begin
         w.result_kind = tse_pkg::KIND_NAME;
         w.name_byte   = b;
         w.sni_found   = 1'b0;
         w.run_last    = !last;
         due_words.push_back(w);
      end
      if (at < POS_MAX) at++;
      if (last) begin
         w.result_kind = tse_pkg::KIND_VERDICT;
         w.name_byte   = '0;
         w.sni_found   = name_done && !broken && at >= rec_end;
         w.run_last    = 1'b1;
         due_words.push_back(w);
         clear_parse();
      end
   endfunction

   initial begin
      fail_count    = 0;
      pending_count = 0;
      clear_parse();
   end

   always @(posedge clock) begin
      tse_pkg::rsp_entry_type got, want;
      if (reset) begin
         clear_parse();
         due_words.delete();
      end else begin
         if (req_chan.valid && req_chan.ready)
            step_parser(req_chan.data_byte, req_chan.packet_end);
         if (rsp_chan.valid && rsp_chan.ready) begin
            got.result_kind = rsp_chan.result_kind;
            got.name_byte   = rsp_chan.name_byte;
            got.sni_found   = rsp_chan.sni_found;
            got.run_last    = rsp_chan.run_last;
            if (due_words.size() == 0) begin
               if (fail_count < SHOW_LIMIT)
                  $display("unexpected word: kind %0d byte %02h found %0d last %0d",
                           got.result_kind, got.name_byte, got.sni_found, got.run_last);
               fail_count++;
            end else begin
               want = due_words.pop_front();
               if (got !== want) begin
                  if (fail_count < SHOW_LIMIT)
                     $display("mismatch: expected %0d/%02h/%0d/%0d got %0d/%02h/%0d/%0d",
                              want.result_kind, want.name_byte, want.sni_found,
                              want.run_last, got.result_kind, got.name_byte,
                              got.sni_found, got.run_last);
                  fail_count++;
               end
            end
         end
      end
      pending_count = due_words.size();
   end

endmodule

/* tb/sv/tb.sv */
// Top of the host name extractor testbench: clock, reset, packet stimulus and the
// result receiver, plus the verdict. Depends on tse_pkg, tse_if,
// tls_sni_extractor_core and tse_sni_checker.
module tb;

   localparam int unsigned POS_BITS     = 17;
   localparam int unsigned CYCLE_LIMIT  = 1000000;
   localparam int unsigned ITEM_GOAL    = 850;
   localparam int unsigned HOLD_AT_WORD = 40;
   localparam int unsigned HOLD_CYCLES  = 2000;
   localparam int unsigned TAIL_CYCLES  = 10;
   localparam logic [15:0] EXT_SERVER_NAME = 16'd0;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   int unsigned fail_count, pending_count;
   int unsigned items_sent = 0;
   int unsigned cycle_count;
   bit          send_calm = 1'b0;
   logic [7:0]  pkt[$];
   int unsigned name_first, name_len;

   tse_req_if req_chan();
   tse_rsp_if rsp_chan();

   tls_sni_extractor_core #(.POSITION_BITS(POS_BITS)) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   tse_sni_checker #(.POSITION_BITS(POS_BITS)) u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_chan      (req_chan),
      .rsp_chan      (rsp_chan),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic void put16(input int unsigned v);
      pkt.push_back(v[15:8]);
      pkt.push_back(v[7:0]);
   endfunction

   function automatic void patch16(input int unsigned idx, input int unsigned v);
      pkt[idx]     = v[15:8];
      pkt[idx + 1] = v[7:0];
   endfunction

   function automatic void put_rand(input int unsigned n);
      repeat (n) pkt.push_back(8'($urandom_range(0, 255)));
   endfunction

   function automatic void add_extension();
      int unsigned n, mark;
      case ($urandom_range(0, 2))
         0: begin
            put16($urandom_range(1, 16'hFFFF));
            n = $urandom_range(0, 6);
            put16(n);
            put_rand(n);
         end
         1: begin
            put16(EXT_SERVER_NAME);
            n = $urandom_range(0, tse_pkg::MIN_NAME_EXT_LEN - 1);
            put16(n);
            put_rand(n);
         end
         default: begin
            // server name list that holds no usable host name
            put16(EXT_SERVER_NAME);
            mark = pkt.size();
            put16(0);
            put16(0);
            if ($urandom_range(0, 1) == 0) begin
               pkt.push_back(tse_pkg::NAME_TYPE_HOST);
               put16(0);
            end else begin
               pkt.push_back(8'($urandom_range(1, 255)));
               n = $urandom_range(0, 3);
               put16(n);
               put_rand(n);
            end
            patch16(mark + 2, pkt.size() - mark - 4);
            put_rand($urandom_range(0, 2));
            patch16(mark, pkt.size() - mark - 2);
         end
      endcase
   endfunction

   function automatic void build_hello(input bit with_name);
      int unsigned n, exts_at, ext_at;
      pkt.delete();
      name_first = 0;
      name_len   = 0;
      pkt.push_back(tse_pkg::REC_TYPE_HANDSHAKE);
      pkt.push_back(8'h03);
      pkt.push_back(8'h01);
      put16(0);
      pkt.push_back(tse_pkg::HS_TYPE_CLIENT_HELLO);
      pkt.push_back(8'h00);
      put16(0);
      pkt.push_back(8'h03);
      pkt.push_back(8'h03);
      put_rand(32);
      n = $urandom_range(0, 8);
      pkt.push_back(8'(n));
      put_rand(n);
      n = 2 * $urandom_range(1, 3);
      put16(n);
      put_rand(n);
      n = $urandom_range(1, 2);
      pkt.push_back(8'(n));
      put_rand(n);
      exts_at = pkt.size();
      put16(0);
      repeat ($urandom_range(0, 2)) add_extension();
      if (with_name) begin
         put16(EXT_SERVER_NAME);
         ext_at = pkt.size();
         put16(0);
         put16(0);
         if ($urandom_range(0, 2) == 0) begin
            pkt.push_back(8'($urandom_range(1, 255)));
            n = $urandom_range(0, 4);
            put16(n);
            put_rand(n);
         end
         if ($urandom_range(0, 3) == 0) begin
            pkt.push_back(tse_pkg::NAME_TYPE_HOST);
            put16(0);
         end
         pkt.push_back(tse_pkg::NAME_TYPE_HOST);
         name_len = $urandom_range(1, 12);
         put16(name_len);
         name_first = pkt.size();
         put_rand(name_len);
         patch16(ext_at + 2, pkt.size() - ext_at - 4);
         if ($urandom_range(0, 2) == 0) put_rand($urandom_range(1, 3));
         patch16(ext_at, pkt.size() - ext_at - 2);
      end
      repeat ($urandom_range(0, 1)) add_extension();
      patch16(exts_at, pkt.size() - exts_at - 2);
      patch16(3, pkt.size() - tse_pkg::RECORD_HEADER_LEN);
      patch16(7, pkt.size() - tse_pkg::HELLO_BODY_POS);
   endfunction

   task automatic send_byte(input logic [7:0] b, input logic last);
      int unsigned gap;
      gap = send_calm ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.data_byte  <= b;
      req_chan.packet_end <= last;
      do @(posedge clock); while (!(req_chan.valid && req_chan.ready));
      items_sent++;
      @(negedge clock);
   endtask

   task automatic send_packet();
      for (int i = 0; i < pkt.size(); i++) send_byte(pkt[i], i == pkt.size() - 1);
   endtask

   initial begin
      int unsigned hold, taken;
      bit calm;
      taken = 0;
      calm  = 1'b0;
      rsp_chan.ready = 1'b0;
      while (reset) @(negedge clock);
      forever begin
         if (taken % 32 == 0) calm = ($urandom_range(0, 2) == 0);
         hold = calm ? 0 : $urandom_range(0, 15);
         // hold off long enough for the block to fill and stall its input
         if (taken == HOLD_AT_WORD) hold = HOLD_CYCLES;
         if (hold > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (hold) @(negedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_chan.valid && rsp_chan.ready));
         taken++;
         @(negedge clock);
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Some tests failed");
      $finish;
   end

   initial begin
      int unsigned keep, idx;
      req_chan.valid      = 1'b0;
      req_chan.data_byte  = '0;
      req_chan.packet_end = 1'b0;
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      pkt = '{8'hFF};
      send_packet();
      pkt = '{8'h00, 8'h80};
      send_packet();
      pkt = '{tse_pkg::REC_TYPE_HANDSHAKE, 8'h03, 8'h01, 8'h00, 8'h26,
              tse_pkg::HS_TYPE_CLIENT_HELLO, 8'h00, 8'h00, 8'h22};
      send_packet();
      pkt = '{tse_pkg::REC_TYPE_HANDSHAKE, 8'h03, 8'h01, 8'hFF, 8'hFF, 8'h02, 8'h7F};
      send_packet();

      while (items_sent < ITEM_GOAL) begin
         send_calm = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 9) == 0) begin
            pkt.delete();
            put_rand($urandom_range(1, 24));
            if ($urandom_range(0, 1) == 0) pkt[0] = tse_pkg::REC_TYPE_HANDSHAKE;
         end else begin
            build_hello($urandom_range(0, 4) != 0);
            case ($urandom_range(0, 9))
               5: begin
                  idx = $urandom_range(0, pkt.size() - 1);
                  pkt[idx] = 8'($urandom_range(0, 255));
               end
               6: begin
                  keep = $urandom_range(1, pkt.size());
                  pkt  = pkt[0:keep - 1];
               end
               7: if (name_len > 0) begin
                  keep = name_first + $urandom_range(1, name_len);
                  pkt  = pkt[0:keep - 1];
               end
               8: put_rand($urandom_range(1, 8));
               9: begin
                  pkt[3] = 8'($urandom_range(0, 255));
                  pkt[4] = 8'($urandom_range(0, 255));
               end
               default: ;
            endcase
         end
         send_packet();
      end
      req_chan.valid <= 1'b0;

      while (pending_count != 0) @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);
      if (fail_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

/* files.f */
rtl/tse_pkg.sv
rtl/tse_if.sv
rtl/tse_parser.sv
rtl/tls_sni_extractor_core.sv
rtl/tse_checker.sv
tb/sv/tse_sni_checker.sv
tb/sv/tb.sv
